[hw/rtl/cpg_pkg.sv]
// ----------------------------------------------------------------------------
// cpg_pkg
// Shared types, constants and helpers for the circle pixel generator.
// ----------------------------------------------------------------------------
package cpg_pkg;

  // Default sizes of the coordinate and decision datapaths.
  localparam int COORD_WIDTH_DEF    = 16;
  localparam int DECISION_WIDTH_DEF = 20;

  // Midpoint decision term constants.
  localparam int DEC_INIT     = 3;
  localparam int DEC_STEP_NEG = 6;
  localparam int DEC_STEP_POS = 10;

  // Configuration register indexes.
  localparam int CFG_ADDR_W = 2;
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_CENTER_X    = 2'd0,
    CFG_CENTER_Y    = 2'd1,
    CFG_RADIUS      = 2'd2,
    CFG_FILL_ENABLE = 2'd3
  } cfg_reg_e;

  // Walk phase, one-hot.
  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_BORDER = 4'b0010,
    PH_FILL   = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_t;

  localparam int OCT_W = 3;
  typedef logic [OCT_W-1:0] oct_t;
  localparam oct_t OCT_LAST = 3'd7;

  // Flags that travel with one base point from walker to emitter.
  typedef struct packed {
    logic is_fill;
    logic done;
  } job_flags_t;

  // Octant mirror controls: swap the base coordinates, negate x, negate y.
  function automatic logic oct_swap(input oct_t k);
    oct_swap = (k == 3'd0) || (k == 3'd3) || (k == 3'd4) || (k == 3'd7);
  endfunction

  function automatic logic oct_negx(input oct_t k);
    oct_negx = (k == 3'd2) || (k == 3'd3) || (k == 3'd4) || (k == 3'd5);
  endfunction

  function automatic logic oct_negy(input oct_t k);
    oct_negy = k[2];
  endfunction

endpackage

[hw/rtl/cpg_walker.sv]
// ----------------------------------------------------------------------------
// cpg_walker
// Midpoint walk over the second octant: border pass, then optional fill pass.
// Each accepted step in the border or fill pass updates the walk and hands one
// base point to the emitter; a restart step or a step after the walk is done hands none.
// ----------------------------------------------------------------------------
module cpg_walker #(
  parameter int COORD_WIDTH    = cpg_pkg::COORD_WIDTH_DEF,
  parameter int DECISION_WIDTH = cpg_pkg::DECISION_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step_fire,
  input  logic                   restart,
  input  logic [COORD_WIDTH-1:0] radius,
  input  logic                   fill_enable,
  output logic                   job_push,
  output logic [COORD_WIDTH-1:0] job_a,
  output logic [COORD_WIDTH-1:0] job_b,
  output cpg_pkg::job_flags_t    job_flags
);
  import cpg_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int DW = DECISION_WIDTH;
  localparam int EW = (DW > CW + 1) ? DW : CW + 1;

  phase_t         phase_r, phase_nxt;
  logic [CW-1:0]  walk_x_r, walk_x_nxt;
  logic [CW-1:0]  walk_y_r, walk_y_nxt;
  logic [DW-1:0]  dec_r, dec_nxt;
  logic [CW-1:0]  fill_row_r, fill_row_nxt;

  // One midpoint step from the current walk point.
  logic [CW:0]    nx;
  logic [CW:0]    ny;
  logic [CW-1:0]  ny_dec;
  logic [DW-1:0]  dec_step;
  logic           step_end;
  logic           step_ok;
  logic           step_open;
  logic [DW-1:0]  dec_start;
  logic [CW:0]    row_inc;

  always_comb begin
    nx       = {1'b0, walk_x_r} + 1'b1;
    ny_dec   = walk_y_r - 1'b1;
    step_end = 1'b0;
    if (dec_r[DW-1]) begin
      dec_step = DW'(EW'(dec_r) + (EW'(nx) << 2) + EW'(DEC_STEP_NEG));
      ny       = {1'b0, walk_y_r};
    end else begin
      dec_step = DW'(EW'(dec_r) + ((EW'(nx) - EW'(walk_y_r)) << 2) + EW'(DEC_STEP_POS));
      if (walk_y_r == '0) begin
        step_end = 1'b1;
        ny       = {1'b0, walk_y_r};
      end else begin
        ny       = {1'b0, ny_dec};
      end
    end
    // Border continues while x <= y; a fill column needs x < y.
    step_ok   = !step_end && (nx <= ny);
    step_open = !step_end && (nx < ny);
    dec_start = DW'(EW'(DEC_INIT) - (EW'(radius) << 1));
    row_inc   = {1'b0, fill_row_r} + 1'b1;
  end

  // Phase sequencing and base point selection.
  always_comb begin
    phase_nxt    = phase_r;
    walk_x_nxt   = walk_x_r;
    walk_y_nxt   = walk_y_r;
    dec_nxt      = dec_r;
    fill_row_nxt = fill_row_r;
    job_push     = 1'b0;
    job_a        = walk_x_r;
    job_b        = walk_y_r;
    job_flags    = '0;
    if (step_fire) begin
      if (restart) begin
        phase_nxt    = PH_BORDER;
        walk_x_nxt   = '0;
        walk_y_nxt   = radius;
        dec_nxt      = dec_start;
        fill_row_nxt = '0;
      end else begin
        unique case (phase_r)
          PH_BORDER: begin
            job_push = 1'b1;
            if (step_ok) begin
              walk_x_nxt = nx[CW-1:0];
              walk_y_nxt = ny[CW-1:0];
              dec_nxt    = dec_step;
            end else if (fill_enable && (radius != '0)) begin
              // Fill pass walks the border again from the top.
              phase_nxt    = PH_FILL;
              walk_x_nxt   = '0;
              walk_y_nxt   = radius;
              dec_nxt      = dec_start;
              fill_row_nxt = '0;
            end else begin
              phase_nxt      = PH_DONE;
              job_flags.done = 1'b1;
            end
          end
          PH_FILL: begin
            job_push          = 1'b1;
            job_b             = fill_row_r;
            job_flags.is_fill = 1'b1;
            if (row_inc < {1'b0, walk_y_r}) begin
              fill_row_nxt = row_inc[CW-1:0];
            end else if (step_open) begin
              // Next column; a column with x equal to y is empty and ends the walk.
              walk_x_nxt   = nx[CW-1:0];
              walk_y_nxt   = ny[CW-1:0];
              dec_nxt      = dec_step;
              fill_row_nxt = nx[CW-1:0];
            end else begin
              phase_nxt      = PH_DONE;
              job_flags.done = 1'b1;
            end
          end
          PH_IDLE, PH_DONE: begin
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Walk state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      walk_x_r   <= '0;
      walk_y_r   <= '0;
      dec_r      <= '0;
      fill_row_r <= '0;
    end else begin
      phase_r    <= phase_nxt;
      walk_x_r   <= walk_x_nxt;
      walk_y_r   <= walk_y_nxt;
      dec_r      <= dec_nxt;
      fill_row_r <= fill_row_nxt;
    end
  end

endmodule

[hw/rtl/cpg_emitter.sv]
// ----------------------------------------------------------------------------
// cpg_emitter
// Holds one base point and sends its eight mirror images, one per cycle
// while pix_ready is high, offset by the center.
// ----------------------------------------------------------------------------
module cpg_emitter #(
  parameter int COORD_WIDTH = cpg_pkg::COORD_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   job_push,
  input  logic [COORD_WIDTH-1:0] job_a,
  input  logic [COORD_WIDTH-1:0] job_b,
  input  cpg_pkg::job_flags_t    job_flags,
  output logic                   job_ready,
  input  logic [COORD_WIDTH-1:0] origin_x,
  input  logic [COORD_WIDTH-1:0] origin_y,
  output logic                   pix_valid,
  input  logic                   pix_ready,
  output logic [COORD_WIDTH-1:0] pix_x,
  output logic [COORD_WIDTH-1:0] pix_y,
  output cpg_pkg::oct_t          pix_oct,
  output logic                   pix_fill,
  output logic                   pix_last,
  output logic                   pix_done
);
  import cpg_pkg::*;

  logic                   valid_r, valid_nxt;
  oct_t                   oct_r, oct_nxt;
  logic [COORD_WIDTH-1:0] a_r, b_r;
  job_flags_t             flags_r;
  logic                   pix_fire;
  logic                   final_fire;
  logic [COORD_WIDTH-1:0] u, v;

  assign pix_fire   = valid_r && pix_ready;
  assign final_fire = pix_fire && (oct_r == OCT_LAST);
  assign job_ready  = !valid_r || final_fire;

  // Octant counter and slot occupancy.
  always_comb begin
    valid_nxt = valid_r;
    oct_nxt   = oct_r;
    if (pix_fire) begin
      oct_nxt = oct_r + 1'b1;
    end
    if (final_fire) begin
      valid_nxt = 1'b0;
    end
    if (job_push) begin
      valid_nxt = 1'b1;
      oct_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      oct_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      oct_r   <= oct_nxt;
    end
  end

  // Base point payload.
  always_ff @(posedge clk) begin
    if (job_push) begin
      a_r     <= job_a;
      b_r     <= job_b;
      flags_r <= job_flags;
    end
  end

  // Mirror and offset for the current octant.
  always_comb begin
    u     = oct_swap(oct_r) ? b_r : a_r;
    v     = oct_swap(oct_r) ? a_r : b_r;
    pix_x = oct_negx(oct_r) ? (origin_x - u) : (origin_x + u);
    pix_y = oct_negy(oct_r) ? (origin_y - v) : (origin_y + v);
  end

  assign pix_valid = valid_r;
  assign pix_oct   = oct_r;
  assign pix_fill  = flags_r.is_fill;
  assign pix_last  = (oct_r == OCT_LAST);
  assign pix_done  = (oct_r == OCT_LAST) && flags_r.done;

endmodule

[hw/rtl/circle_pixel_generator_unit.sv]
// ----------------------------------------------------------------------------
// circle_pixel_generator_unit
// Midpoint circle rasterizer with optional interior fill.
// ----------------------------------------------------------------------------
// Usage:
//   Configure the center, radius and fill switch through the cfg_ write port
//   while the block is idle. Each word on the in_ channel is one step: with
//   restart set it loads a new circle and sends nothing; otherwise it
//   advances the walk by one base point and sends eight pixel words on the
//   out_ channel, octants 0 to 7, the eighth marked by out_tlast. The final
//   pixel of the circle carries the circle-done flag. After that, and before
//   any restart, steps send nothing.
//   The first pixel of a step is valid the cycle after the step is taken.
//   Throughput: one pixel per cycle while out_tready is high. The walker can
//   take the next step in the same cycle the eighth pixel of the previous
//   one is taken.
//   Reset clears all registers but the emitter's base point payload and
//   leaves the walk idle. When the receiver stalls, the current pixel holds.
//   in_tready stays low while a base point is being sent, except in the
//   cycle its eighth pixel is taken.
// ----------------------------------------------------------------------------
module circle_pixel_generator_unit #(
  parameter int COORD_WIDTH    = cpg_pkg::COORD_WIDTH_DEF,
  parameter int DECISION_WIDTH = cpg_pkg::DECISION_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Configuration write port.
  input  logic                            cfg_we,
  input  logic [cpg_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [COORD_WIDTH-1:0]          cfg_data,
  // Step channel.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [0] restart
  // Pixel channel.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [((2*COORD_WIDTH+cpg_pkg::OCT_W+7)/8)*8-1:0] out_tdata,
                                                      // pixel_x, pixel_y, octant
  output logic                            out_tlast,  // last_of_step
  output logic [1:0]                      out_tuser   // [0] is_fill, [1] circle_done
);
  import cpg_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int TD_W = ((2 * CW + OCT_W + 7) / 8) * 8;
  localparam int PAD  = TD_W - 2 * CW - OCT_W;

  logic [CW-1:0] origin_x_r, origin_y_r, radius_r;
  logic          fill_enable_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r    <= '0;
      origin_y_r    <= '0;
      radius_r      <= '0;
      fill_enable_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_addr))
        CFG_CENTER_X:    origin_x_r    <= cfg_data;
        CFG_CENTER_Y:    origin_y_r    <= cfg_data;
        CFG_RADIUS:      radius_r      <= cfg_data;
        CFG_FILL_ENABLE: fill_enable_r <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  logic          job_push, job_ready;
  logic [CW-1:0] job_a, job_b;
  job_flags_t    job_flags;
  logic          step_fire;

  assign in_tready = job_ready;
  assign step_fire = in_tvalid && job_ready;

  cpg_walker #(
    .COORD_WIDTH    (COORD_WIDTH),
    .DECISION_WIDTH (DECISION_WIDTH)
  ) u_walker (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_fire   (step_fire),
    .restart     (in_tdata[0]),
    .radius      (radius_r),
    .fill_enable (fill_enable_r),
    .job_push    (job_push),
    .job_a       (job_a),
    .job_b       (job_b),
    .job_flags   (job_flags)
  );

  logic [CW-1:0] pix_x, pix_y;
  oct_t          pix_oct;
  logic          pix_fill, pix_done;

  cpg_emitter #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_emitter (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_push  (job_push),
    .job_a     (job_a),
    .job_b     (job_b),
    .job_flags (job_flags),
    .job_ready (job_ready),
    .origin_x  (origin_x_r),
    .origin_y  (origin_y_r),
    .pix_valid (out_tvalid),
    .pix_ready (out_tready),
    .pix_x     (pix_x),
    .pix_y     (pix_y),
    .pix_oct   (pix_oct),
    .pix_fill  (pix_fill),
    .pix_last  (out_tlast),
    .pix_done  (pix_done)
  );

  // Pack the pixel word, first field in the lowest bits.
  assign out_tdata = TD_W'({{PAD{1'b0}}, pix_oct, pix_y, pix_x});
  assign out_tuser = {pix_done, pix_fill};

endmodule

[hw/rtl/cpg_checker.sv]
// ----------------------------------------------------------------------------
// cpg_checker
// Port-level checks on the pixel channel of the circle pixel generator.
// ----------------------------------------------------------------------------
module cpg_checker #(
  parameter int COORD_WIDTH = cpg_pkg::COORD_WIDTH_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [((2*COORD_WIDTH+cpg_pkg::OCT_W+7)/8)*8-1:0] out_tdata,
  input logic                   out_tlast,
  input logic [1:0]             out_tuser
);
  import cpg_pkg::*;

  localparam int OB = 2 * COORD_WIDTH;

  oct_t oct;
  assign oct = out_tdata[OB +: OCT_W];

  // The word that closes a step is always octant 7.
  a_last_is_oct7: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> oct == OCT_LAST)
    else $error("tlast on a pixel other than octant 7");

  // Circle done only on the word that closes a step.
  a_done_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tlast)
    else $error("circle done without tlast");

  // The eight images of a step follow one another without gaps.
  a_octant_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid && oct == $past(oct) + 3'd1)
    else $error("octant sequence broken within a step");

  // A stalled pixel word holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("pixel word changed while stalled");

  // Nothing is offered right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("pixel valid after reset");

endmodule

bind circle_pixel_generator_unit cpg_checker #(
  .COORD_WIDTH (COORD_WIDTH)
) u_cpg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
